@@ hdl/calendar_date_offset_assert.svh @@
// Assertion macros used by the checker in cdo_check.sv.
`ifndef CALENDAR_DATE_OFFSET_ASSERT_SVH
`define CALENDAR_DATE_OFFSET_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define CDO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define CDO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/cdo_pkg.sv @@
package cdo_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;
  localparam int unsigned YearMod      = 400;
  localparam int unsigned MonthsPerYr  = 12;
  localparam int unsigned ModSteps     = 6;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MONTH = 2'd1,
    ST_BAD_DAY   = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_WALK,
    S_FIN
  } state_t;

  // Working date of the walk; rem is the year modulo 400.
  typedef struct packed {
    logic signed [16:0] year;
    logic [8:0]         rem;
    logic [3:0]         month;
    logic signed [16:0] day;
  } walk_t;

  typedef struct packed {
    logic fwd;
    logic bwd;
  } step_flags_t;

  function automatic logic is_leap(input logic [8:0] rem);
    logic century;
    century = (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
    return (rem[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] md;
    unique case (month)
      4'd2:                         md = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      md = 5'd30;
      default:                      md = 5'd31;
    endcase
    return md;
  endfunction

endpackage

@@ hdl/cdo_step.sv @@
module cdo_step (
  input  cdo_pkg::walk_t       cur,
  output cdo_pkg::walk_t       nxt,
  output cdo_pkg::step_flags_t flags
);

  localparam logic [3:0] LastMonth = 4'(cdo_pkg::MonthsPerYr);
  localparam logic [8:0] LastRem   = 9'(cdo_pkg::YearMod - 1);

  logic [4:0]         md_cur;
  logic [4:0]         md_prev;
  logic [3:0]         prev_month;
  logic [8:0]         prev_rem;
  logic signed [16:0] prev_year;
  logic               wrap_back;
  logic               wrap_fwd;
  logic signed [16:0] addend;

  always_comb begin
    md_cur     = cdo_pkg::month_days(cur.month, cdo_pkg::is_leap(cur.rem));
    wrap_back  = (cur.month <= 4'd1);
    wrap_fwd   = (cur.month >= LastMonth);
    prev_month = wrap_back ? LastMonth : cur.month - 4'd1;
    prev_rem   = wrap_back ? ((cur.rem == 9'd0) ? LastRem : cur.rem - 9'd1) : cur.rem;
    prev_year  = wrap_back ? cur.year - 17'sd1 : cur.year;
    md_prev    = cdo_pkg::month_days(prev_month, cdo_pkg::is_leap(prev_rem));

    flags.fwd = (cur.day > $signed({12'd0, md_cur}));
    flags.bwd = (cur.day < 17'sd1);

    // One adder serves both directions: subtract this month or add the previous one.
    addend = flags.fwd ? -$signed({12'd0, md_cur}) : $signed({12'd0, md_prev});

    nxt = cur;
    if (flags.fwd) begin
      nxt.day = cur.day + addend;
      if (wrap_fwd) begin
        nxt.month = 4'd1;
        nxt.year  = cur.year + 17'sd1;
        nxt.rem   = (cur.rem == LastRem) ? 9'd0 : cur.rem + 9'd1;
      end else begin
        nxt.month = cur.month + 4'd1;
      end
    end else if (flags.bwd) begin
      nxt.day   = cur.day + addend;
      nxt.month = prev_month;
      nxt.year  = prev_year;
      nxt.rem   = prev_rem;
    end
  end

endmodule

@@ hdl/calendar_date_offset.sv @@
// Channel  Dir  Width  Contents
// s_*      in   40     start_year, start_month, start_day, day_offset
// m_*      out  24+2   result_year, result_month, result_day; status in m_tuser
//
// A valid date is walked N months, up to about 1080, one month per cycle; a bad
// date skips the walk and goes straight to the output register.
// The year modulo 400 is found first by conditionally subtracting shifted copies of 400.
// s_tready is high only while idle; a finished result waits in the output
// register, and the next item can be accepted while it stalls there.
// rst is synchronous and clears the sequencer and m_tvalid.
module calendar_date_offset #(
  parameter int unsigned MAX_YEAR = cdo_pkg::MAX_YEAR_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [38:23] day_offset, [39] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [13:0] result_year, [17:14] result_month, [22:18] result_day, [23] zero
  output logic [23:0] m_tdata,
  // [1:0] status
  output logic [1:0]  m_tuser
);

  localparam logic signed [16:0] MaxYear = $signed({1'b0, 16'(MAX_YEAR)});
  localparam logic [2:0] LastModStep = 3'(cdo_pkg::ModSteps - 1);

  cdo_pkg::state_t      state, state_next;
  cdo_pkg::walk_t       w, w_step;
  cdo_pkg::step_flags_t flags;
  cdo_pkg::status_t     status;
  logic [13:0]          acc, acc_next, sub;
  logic [2:0]           k;
  logic signed [15:0]   offset;
  logic                 s_fire, out_load, bad_month, in_range;

  cdo_step u_step (
    .cur   (w),
    .nxt   (w_step),
    .flags (flags)
  );

  assign s_fire    = s_tvalid && s_tready;
  assign bad_month = (w.month == 4'd0) || (w.month > 4'(cdo_pkg::MonthsPerYr));
  assign in_range  = !w.year[16] && (w.year <= MaxYear);

  always_comb begin
    sub      = 14'(cdo_pkg::YearMod) << (LastModStep - k);
    acc_next = (acc >= sub) ? acc - sub : acc;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cdo_pkg::S_IDLE:  if (s_fire) state_next = cdo_pkg::S_MOD;
      cdo_pkg::S_MOD:   if (k == LastModStep) state_next = cdo_pkg::S_CHECK;
      cdo_pkg::S_CHECK: begin
        if (bad_month || flags.fwd || flags.bwd) state_next = cdo_pkg::S_FIN;
        else state_next = cdo_pkg::S_WALK;
      end
      cdo_pkg::S_WALK:  if (!flags.fwd && !flags.bwd) state_next = cdo_pkg::S_FIN;
      cdo_pkg::S_FIN:   if (out_load) state_next = cdo_pkg::S_IDLE;
      default:          state_next = cdo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == cdo_pkg::S_IDLE);
    out_load = (state == cdo_pkg::S_FIN) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdo_pkg::S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == cdo_pkg::S_MOD) k <= k + 3'd1;
      else k <= '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      cdo_pkg::S_IDLE: begin
        if (s_fire) begin
          w.year  <= $signed({3'd0, s_tdata[13:0]});
          w.month <= s_tdata[17:14];
          w.day   <= $signed({12'd0, s_tdata[22:18]});
          w.rem   <= '0;
          acc     <= s_tdata[13:0];
          offset  <= $signed(s_tdata[38:23]);
        end
      end
      cdo_pkg::S_MOD: begin
        acc   <= acc_next;
        w.rem <= acc_next[8:0];
      end
      cdo_pkg::S_CHECK: begin
        // Month is checked before the day.
        if (bad_month) status <= cdo_pkg::ST_BAD_MONTH;
        else if (flags.fwd || flags.bwd) status <= cdo_pkg::ST_BAD_DAY;
        else w.day <= w.day + 17'(offset);
      end
      cdo_pkg::S_WALK: begin
        w <= w_step;
        if (!flags.fwd && !flags.bwd) begin
          status <= in_range ? cdo_pkg::ST_OK : cdo_pkg::ST_RANGE;
        end
      end
      cdo_pkg::S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= status;
      if (status == cdo_pkg::ST_OK) begin
        m_tdata <= {1'b0, w.day[4:0], w.month, w.year[13:0]};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

@@ hdl/cdo_check.sv @@
`include "calendar_date_offset_assert.svh"

module cdo_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result stays offered.
  `CDO_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
  // A stalled result keeps its payload.
  `CDO_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
  // Any error code comes with an all-zero date.
  `CDO_ASSERT_NOW(a_err_zero, m_tvalid && (m_tuser != cdo_pkg::ST_OK), m_tdata == 24'd0)
  // A good result carries a real month and day.
  `CDO_ASSERT_NOW(a_ok_date, m_tvalid && (m_tuser == cdo_pkg::ST_OK),
    (m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12) && (m_tdata[22:18] != 5'd0))
  // The block works on one item at a time.
  `CDO_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready)

endmodule

bind calendar_date_offset cdo_check u_cdo_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
